FILE: src/cpualu_pkg.sv
package cpualu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int OP_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_MOV = 4'd0,
    OP_AND = 4'd1,
    OP_IOR = 4'd2,
    OP_INC = 4'd3,
    OP_DEC = 4'd4,
    OP_NOT = 4'd5,
    OP_ADD = 4'd6,
    OP_CMP = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9
  } op_t;

endpackage

FILE: src/cpu_alu_with_flags_unit.sv
// ALU with flags for a small CPU core. One transaction in carries an operation code
// (MOV, AND, IOR, INC, DEC, NOT, ADD, CMP, MUL, DIV), the destination and source
// words and the current flags; exactly one transaction comes out, in order, with the
// value to write, its write enable, the new zero/sign/carry/overflow flags, an
// optional stack push word and a divide fault. Codes 10 to 15 do nothing (no write,
// flags kept). The unit takes a new transaction every cycle unless the output is
// stalled with every stage full. Each one passes stage 0 for operand decode, the
// multiplier and the adder, then the restoring divider, one quotient bit per stage,
// which every operation passes through. Stages advance independently, so bubbles
// are squeezed out while the output is stalled.
module cpu_alu_with_flags_unit #(
  parameter int DATA_WIDTH = cpualu_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cpualu_pkg::OP_W-1:0] operation,
  input  logic [DATA_WIDTH-1:0]       dest_value,
  input  logic [DATA_WIDTH-1:0]       src_value,
  input  logic                        carry_in,
  input  logic                        zero_in,
  input  logic                        sign_in,
  input  logic                        overflow_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [DATA_WIDTH-1:0]       result_value,
  output logic                        write_enable,
  output logic                        zero_out,
  output logic                        sign_out,
  output logic                        carry_out,
  output logic                        overflow_out,
  output logic [DATA_WIDTH-1:0]       push_value,
  output logic                        push_valid,
  output logic                        divide_fault
);
  import cpualu_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NS = W + 1;   // stage 0 plus one stage per quotient bit

  // payload carried down the pipe
  typedef struct packed {
    logic [W-1:0] res;
    logic         we;
    logic         z;
    logic         n;
    logic         c;
    logic         v;
    logic [W-1:0] pv;
    logic         pvalid;
    logic         fault;
    logic         is_div;  // DIV with nonzero divisor, fixed up at the last stage
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
  } stage_t;

  stage_t      st [NS];
  stage_t      st_next [NS];
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  // ---------------------------------------------------------------- stage 0 decode
  logic [W:0]     sum;
  logic [2*W-1:0] prod;
  logic [W-1:0]   diff;
  logic [W-1:0]   logic_res;
  op_t            op;
  stage_t         s0;

  assign op   = op_t'(operation);
  assign sum  = {1'b0, dest_value} + {1'b0, src_value} + {{W{1'b0}}, carry_in};
  assign prod = dest_value * src_value;
  assign diff = dest_value - src_value;

  always_comb begin
    logic_res    = dest_value;
    s0           = '0;
    s0.res       = dest_value;
    s0.we        = 1'b1;
    s0.z         = zero_in;
    s0.n         = sign_in;
    s0.c         = carry_in;
    s0.v         = overflow_in;
    s0.quo       = dest_value;
    s0.dvs       = src_value;
    unique case (op)
      OP_MOV: logic_res = src_value;
      OP_AND: logic_res = dest_value & src_value;
      OP_IOR: logic_res = dest_value | src_value;
      OP_INC: logic_res = dest_value + W'(1);
      OP_DEC: logic_res = dest_value - W'(1);
      OP_NOT: logic_res = ~dest_value;
      default: logic_res = dest_value;
    endcase
    unique case (op)
      OP_MOV, OP_AND, OP_IOR, OP_INC, OP_DEC, OP_NOT: begin
        s0.res = logic_res;
        s0.z   = (logic_res == '0);
        s0.n   = logic_res[W-1];
      end
      OP_ADD: begin
        s0.res = sum[W-1:0];
        s0.z   = (sum == '0);
        s0.n   = sum[W-1];
        s0.c   = sum[W];
        s0.v   = (dest_value[W-1] ^ sum[W-1]) & (src_value[W-1] ^ sum[W-1]);
      end
      OP_MUL: begin
        s0.res = prod[W-1:0];
        s0.z   = (prod == '0);
        s0.n   = prod[W-1];
        s0.c   = |prod[2*W-1:W];
        s0.v   = (dest_value[W-1] ^ prod[W-1]) & (src_value[W-1] ^ prod[W-1]);
        if (|prod[2*W-1:W]) begin
          s0.pv     = prod[2*W-1:W];
          s0.pvalid = 1'b1;
        end
      end
      OP_CMP: begin
        s0.we = 1'b0;
        s0.c  = (dest_value >= src_value);
        s0.z  = (dest_value == src_value);
        s0.n  = diff[W-1];
      end
      OP_DIV: begin
        s0.pvalid = 1'b1;
        if (src_value == '0) begin
          // divide by zero: push old destination, write all ones, flags kept
          s0.pv    = dest_value;
          s0.res   = '1;
          s0.fault = 1'b1;
        end else begin
          s0.is_div = 1'b1;
        end
      end
      default: s0.we = 1'b0;  // unused codes
    endcase
  end

  assign st_next[0] = s0;

  // ------------------------------------------------------- restoring divider stages
  for (genvar i = 1; i < NS; i++) begin : g_div
    logic [W:0] t;
    logic [W:0] td;
    logic       ge;
    assign t  = {st[i-1].rem, st[i-1].quo[W-1]};
    assign td = t - {1'b0, st[i-1].dvs};
    assign ge = (t >= {1'b0, st[i-1].dvs});
    always_comb begin
      st_next[i]     = st[i-1];
      st_next[i].rem = ge ? td[W-1:0] : t[W-1:0];
      st_next[i].quo = {st[i-1].quo[W-2:0], ge};
      if (i == NS - 1 && st[i-1].is_div) begin
        st_next[i].res = {st[i-1].quo[W-2:0], ge};
        st_next[i].pv  = ge ? td[W-1:0] : t[W-1:0];
        st_next[i].z   = ({st[i-1].quo[W-2:0], ge} == '0);
        st_next[i].n   = st[i-1].quo[W-2];
        st_next[i].c   = 1'b0;
      end
    end
  end

  // ------------------------------------------------------------- flow control
  // a stage may take new data when it is empty or its content moves on
  always_comb begin
    adv[NS-1] = !vld[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) st[i] <= st_next[i];
    end
  end

  // ------------------------------------------------------------------ outputs
  assign out_valid    = vld[NS-1];
  assign result_value = st[NS-1].res;
  assign write_enable = st[NS-1].we;
  assign zero_out     = st[NS-1].z;
  assign sign_out     = st[NS-1].n;
  assign carry_out    = st[NS-1].c;
  assign overflow_out = st[NS-1].v;
  assign push_value   = st[NS-1].pv;
  assign push_valid   = st[NS-1].pvalid;
  assign divide_fault = st[NS-1].fault;

  // --------------------------------------------------------------- assertions
  a_fault_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_fault |-> push_valid && write_enable && (result_value == '1))
    else $error("divide fault without push or all-ones write");

  a_nowrite_nopush: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> !push_valid && !divide_fault)
    else $error("push or fault on a non-writing operation");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transaction lost at stage 0");

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpualu_pkg::*;

  localparam int W = 16;
  localparam int PIPE_DEPTH = W + 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [W-1:0] value;
    logic         we;
    logic         z;
    logic         n;
    logic         c;
    logic         v;
    logic [W-1:0] push;
    logic         push_en;
    logic         fault;
  } alu_res_t;

  // Mismatch counter lives at module scope so the report task can bump it.
  int errors = 0;

  task automatic report(input string what, input int idx, input logic [W-1:0] got,
                        input logic [W-1:0] want);
    $display("mismatch %s on result %0d: got %h want %h", what, idx, got, want);
    errors++;
  endtask

  // Scoreboard: computes the expected ALU result and checks returned ones in order.
  class alu_scoreboard;
    alu_res_t pending[$];
    int       checked;

    function alu_res_t compute(logic [3:0] op, logic [W-1:0] d, logic [W-1:0] s,
                               logic ci, logic zi, logic ni, logic vi);
      alu_res_t r;
      logic [2*W-1:0] full;
      logic [W-1:0] diff;
      logic uses_logic;
      r = '0;
      r.value = d; r.we = 1; r.z = zi; r.n = ni; r.c = ci; r.v = vi;
      uses_logic = 0;
      full = '0;
      case (op)
        OP_MOV: begin r.value = s; uses_logic = 1; end
        OP_AND: begin r.value = d & s; uses_logic = 1; end
        OP_IOR: begin r.value = d | s; uses_logic = 1; end
        OP_INC: begin r.value = d + 1'b1; uses_logic = 1; end
        OP_DEC: begin r.value = d - 1'b1; uses_logic = 1; end
        OP_NOT: begin r.value = ~d; uses_logic = 1; end
        OP_ADD, OP_MUL: begin
          if (op == OP_ADD) full = {{W{1'b0}}, d} + {{W{1'b0}}, s} + ci;
          else full = {{W{1'b0}}, d} * {{W{1'b0}}, s};
          r.z = (full == 0);
          r.n = full[W-1];
          r.c = (full[2*W-1:W] != 0);
          r.v = ((d ^ full[W-1:0]) & (s ^ full[W-1:0]) & (1 << (W-1))) != 0;
          r.value = full[W-1:0];
          if (op == OP_MUL && r.c) begin r.push = full[2*W-1:W]; r.push_en = 1; end
        end
        OP_CMP: begin
          diff = d - s;
          r.we = 0; r.c = (d >= s); r.z = (d == s); r.n = diff[W-1];
        end
        OP_DIV: begin
          r.push_en = 1;
          if (s == 0) begin
            r.push = d; r.value = '1; r.fault = 1;
          end else begin
            r.value = d / s; r.push = d % s;
            r.z = (r.value == 0); r.n = r.value[W-1]; r.c = 0;
          end
        end
        default: r.we = 0; // unused codes: nothing written, flags kept
      endcase
      if (uses_logic) begin
        r.z = (r.value == 0);
        r.n = r.value[W-1];
      end
      return r;
    endfunction

    function void note_input(logic [3:0] op, logic [W-1:0] d, logic [W-1:0] s,
                             logic ci, logic zi, logic ni, logic vi);
      pending.push_back(compute(op, d, s, ci, zi, ni, vi));
    endfunction

    task check_result(alu_res_t got);
      alu_res_t want;
      if (pending.size() == 0) begin
        report("unexpected result", checked, got.value, '0);
        checked++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) report("result_value", checked, got.value, want.value);
      if (got.we !== want.we) report("write_enable", checked, got.we, want.we);
      if (got.z !== want.z) report("zero_out", checked, got.z, want.z);
      if (got.n !== want.n) report("sign_out", checked, got.n, want.n);
      if (got.c !== want.c) report("carry_out", checked, got.c, want.c);
      if (got.v !== want.v) report("overflow_out", checked, got.v, want.v);
      if (got.push !== want.push) report("push_value", checked, got.push, want.push);
      if (got.push_en !== want.push_en)
        report("push_valid", checked, got.push_en, want.push_en);
      if (got.fault !== want.fault) report("divide_fault", checked, got.fault, want.fault);
      checked++;
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 1;
  logic [OP_W-1:0] operation = '0;
  logic [W-1:0] dest_value = '0, src_value = '0;
  logic carry_in = 0, zero_in = 0, sign_in = 0, overflow_in = 0;
  logic [W-1:0] result_value, push_value;
  logic write_enable, zero_out, sign_out, carry_out, overflow_out, push_valid, divide_fault;

  // Idle rates in percent; changed between phases by the stimulus process.
  int send_idle_pct = 17, recv_idle_pct = 53;
  // Long receiver hold-off, counted down in the receiver process.
  int hold_cycles = 0;
  longint cycle_count = 0;

  alu_scoreboard sb = new();

  cpu_alu_with_flags_unit #(.DATA_WIDTH(W)) uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Watchdog on a cycle counter.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: input transactions feed the scoreboard, output ones are checked.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(operation, dest_value, src_value, carry_in, zero_in, sign_in,
                    overflow_in);
    if (!rst && out_valid && !out_stall)
      sb.check_result('{result_value, write_enable, zero_out, sign_out, carry_out,
                        overflow_out, push_value, push_valid, divide_fault});
  end

  // Receiver: random stall at the falling edge, plus the long hold-off.
  always @(negedge clk) begin
    if (rst) out_stall <= 1;
    else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one transaction, hold it until accepted, with random gaps before it.
  // Valid stays high on return so the next transaction can follow back to back.
  task automatic send_op(input logic [3:0] op, input logic [W-1:0] d, input logic [W-1:0] s,
                         input logic [3:0] flags);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    operation <= op; dest_value <= d; src_value <= s;
    {carry_in, zero_in, sign_in, overflow_in} <= flags;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Random operand, biased toward edge values.
  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return W'($urandom_range(15));
      default: return W'($urandom());
    endcase
  endfunction

  task automatic random_burst(input int n);
    logic [3:0] op;
    repeat (n) begin
      // Mostly defined codes; unused codes now and then.
      op = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      send_op(op, pick_word(), pick_word(), 4'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: each operation, edges, overflow/carry corners, divide by zero.
    send_op(OP_MOV, 16'h0000, 16'h0000, 4'b0000);
    send_op(OP_MOV, 16'h1234, 16'hFFFF, 4'b1111);
    send_op(OP_AND, 16'hFFFF, 16'h8000, 4'b0101);
    send_op(OP_IOR, 16'h0000, 16'h0000, 4'b1010);
    send_op(OP_INC, 16'hFFFF, 16'h0000, 4'b0000);
    send_op(OP_INC, 16'h7FFF, 16'h0000, 4'b1111);
    send_op(OP_DEC, 16'h0000, 16'h0000, 4'b0000);
    send_op(OP_NOT, 16'hFFFF, 16'h0000, 4'b1111);
    send_op(OP_ADD, 16'hFFFF, 16'h0000, 4'b1000);
    send_op(OP_ADD, 16'h7FFF, 16'h0001, 4'b0000);
    send_op(OP_ADD, 16'h8000, 16'h8000, 4'b0000);
    send_op(OP_ADD, 16'h0000, 16'h0000, 4'b0111);
    send_op(OP_CMP, 16'h1234, 16'h1234, 4'b0001);
    send_op(OP_CMP, 16'h0000, 16'hFFFF, 4'b1110);
    send_op(OP_MUL, 16'hFFFF, 16'hFFFF, 4'b0000);
    send_op(OP_MUL, 16'h0100, 16'h0100, 4'b1111);
    send_op(OP_MUL, 16'h00FF, 16'h0101, 4'b0000);
    send_op(OP_DIV, 16'hFFFF, 16'h0001, 4'b1111);
    send_op(OP_DIV, 16'h1234, 16'h0000, 4'b1010);
    send_op(OP_DIV, 16'h0003, 16'h0007, 4'b0101);
    send_op(4'd10, 16'hABCD, 16'h0000, 4'b1111);
    send_op(4'd15, 16'h5555, 16'hAAAA, 4'b0000);

    random_burst(150);
    // Pause the sender until every result is back.
    drain();

    // Long receiver hold-off while the sender keeps offering: fills the pipe.
    hold_cycles = 3 * PIPE_DEPTH + 10;
    send_idle_pct = 0;
    random_burst(40);

    send_idle_pct = 53; recv_idle_pct = 17;
    random_burst(150);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_burst(160);

    drain();
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (errors == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: sim.f
src/cpualu_pkg.sv
src/cpu_alu_with_flags_unit.sv
dv/tb.sv
